[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the phase coherence block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[rtl/pcop_pkg.sv]
// Package for the phase coherence order parameter block.
// Holds payload structs, controller states, command and status structs, CORDIC table.
`default_nettype none
package pcop_pkg;
	typedef struct packed {
		logic [15:0] phase_angle;
		logic        last_phase;
	} in_item_t;

	typedef struct packed {
		logic [15:0] coherence;
		logic [10:0] phase_count;
		logic        too_many;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CORDIC, ST_ACCUM, ST_SQUARE, ST_SQRT, ST_DIVIDE, ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the item and start the rotation
		logic rot_step;  // one CORDIC iteration
		logic accum;     // add the rotated vector into the sums
		logic square;    // form the squared magnitude
		logic sqrt_init;
		logic sqrt_step;
		logic div_init;
		logic div_step;
		logic emit;      // show result and clear the sums
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;      // count has reached its limit
		logic last;      // captured item closes the set
	} stat_t;

	function automatic logic [23:0] atan_turn24(input logic [3:0] i);
		case (i)
			4'd0: atan_turn24 = 24'd2097152;
			4'd1: atan_turn24 = 24'd1238021;
			4'd2: atan_turn24 = 24'd654136;
			4'd3: atan_turn24 = 24'd332050;
			4'd4: atan_turn24 = 24'd166669;
			4'd5: atan_turn24 = 24'd83416;
			4'd6: atan_turn24 = 24'd41718;
			4'd7: atan_turn24 = 24'd20860;
			4'd8: atan_turn24 = 24'd10430;
			4'd9: atan_turn24 = 24'd5215;
			4'd10: atan_turn24 = 24'd2608;
			4'd11: atan_turn24 = 24'd1304;
			4'd12: atan_turn24 = 24'd652;
			4'd13: atan_turn24 = 24'd326;
			4'd14: atan_turn24 = 24'd163;
			default: atan_turn24 = 24'd81;
		endcase
	endfunction
endpackage
`default_nettype wire

[rtl/pcop_ctrl.sv]
// Controller state machine of the phase coherence block.
// Depends on pcop_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module pcop_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  pcop_pkg::stat_t  stat,
	output pcop_pkg::cmd_t   cmd
);
	pcop_pkg::state_t state_q, state_d;
	logic [4:0] cnt_q, cnt_d;

	// State and step counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcop_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		busy = (state_q != pcop_pkg::ST_IDLE);
		case (state_q)
			pcop_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cnt_d = '0;
					state_d = pcop_pkg::ST_CORDIC;
				end
			end
			pcop_pkg::ST_CORDIC: begin
				cmd.rot_step = 1'b1;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd15) state_d = pcop_pkg::ST_ACCUM;
			end
			pcop_pkg::ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d = stat.last ? pcop_pkg::ST_SQUARE : pcop_pkg::ST_IDLE;
			end
			pcop_pkg::ST_SQUARE: begin
				cmd.square = 1'b1;
				cmd.sqrt_init = 1'b1;
				cnt_d = '0;
				state_d = pcop_pkg::ST_SQRT;
			end
			pcop_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd27) begin
					cnt_d = '0;
					state_d = pcop_pkg::ST_DIVIDE;
				end
			end
			pcop_pkg::ST_DIVIDE: begin
				if (cnt_q == 5'd0) cmd.div_init = 1'b1;
				else cmd.div_step = 1'b1;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd28) state_d = pcop_pkg::ST_EMIT;
			end
			pcop_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = pcop_pkg::ST_IDLE;
			end
			default: state_d = pcop_pkg::ST_IDLE;
		endcase
	end

	`ASSERT_NEXT(a_load_leaves_idle, clk, arst_n, cmd.load, state_q == pcop_pkg::ST_CORDIC, "load did not start rotation")
	`ASSERT_IMPL(a_emit_busy, clk, arst_n, cmd.emit, busy, "emit while idle")
	`ASSERT_NEXT(a_emit_idle, clk, arst_n, cmd.emit, !busy, "busy after emit")
endmodule
`default_nettype wire

[rtl/pcop_datapath.sv]
// Datapath of the phase coherence block: CORDIC, accumulators, square root, divider.
// Depends on pcop_pkg.
`default_nettype none
module pcop_datapath #(
	parameter int unsigned MAX_PHASES = 1024,
	parameter int unsigned ANGLE_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pcop_pkg::in_item_t  item,
	input  pcop_pkg::cmd_t      cmd,
	output pcop_pkg::stat_t     stat,
	output logic                done,
	output pcop_pkg::out_item_t result
);
	localparam int unsigned CntW = $clog2(MAX_PHASES + 1);

	logic signed [32:0] x_q, y_q;
	logic signed [24:0] z_q;
	logic [3:0]  step_q;
	logic [1:0]  quad_q;
	logic        last_q;
	logic signed [26:0] csum_q, ssum_q;
	logic [CntW-1:0] cnt_q;
	logic        ovf_q;
	logic [27:0] rem_q;
	logic [27:0] root_q;
	logic [55:0] sq_w;
	logic [28:0] drem_q;
	logic [15:0] quo_q;
	logic [27:0] dnum_q;

	logic [23:0] a24;
	always_comb begin
		logic [ANGLE_BITS-1:0] a;
		a = ANGLE_BITS'(item.phase_angle);
		a24 = 24'(a) << (24 - ANGLE_BITS);
	end

	assign stat.full = (cnt_q == CntW'(MAX_PHASES));
	assign stat.last = last_q;

	// CORDIC rotation, one iteration per cycle.
	logic signed [32:0] dx, dy;
	logic signed [24:0] at;
	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign at = 25'(pcop_pkg::atan_turn24(step_q));
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= 33'sd652032874;
			y_q <= '0;
			z_q <= 25'(a24[21:0]);
			quad_q <= a24[23:22];
			last_q <= item.last_phase;
			step_q <= '0;
		end else if (cmd.rot_step) begin
			if (!z_q[24]) begin
				x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
			end
			step_q <= step_q + 4'd1;
		end
	end

	// Rounding to Q1.15 and quadrant mapping.
	function automatic logic signed [17:0] q15(input logic signed [32:0] v);
		logic signed [33:0] r;
		r = (34'(v) + 34'sd16384) >>> 15;
		if (r > 34'sd32768) q15 = 18'sd32768;
		else if (r < -34'sd32768) q15 = -18'sd32768;
		else q15 = r[17:0];
	endfunction
	logic signed [17:0] c15, s15, co, si;
	always_comb begin
		c15 = q15(x_q);
		s15 = q15(y_q);
		case (quad_q)
			2'd0: begin co = c15; si = s15; end
			2'd1: begin co = -s15; si = c15; end
			2'd2: begin co = -c15; si = -s15; end
			default: begin co = s15; si = -c15; end
		endcase
	end

	function automatic logic signed [26:0] sat(input logic signed [26:0] a,
			input logic signed [17:0] b);
		logic signed [27:0] r;
		r = 28'(a) + 28'(b);
		if (r > 28'sd67108863) sat = 27'sd67108863;
		else if (r < -28'sd67108864) sat = -27'sd67108864;
		else sat = r[26:0];
	endfunction

	// Accumulators, count and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csum_q <= '0; ssum_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
		end else if (cmd.emit) begin
			csum_q <= '0; ssum_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
		end else if (cmd.accum) begin
			if (stat.full) ovf_q <= 1'b1;
			else begin
				csum_q <= sat(csum_q, co);
				ssum_q <= sat(ssum_q, si);
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Squared magnitude: two 27x27 products summed.
	logic [26:0] cm, sm;
	logic [53:0] csq_w, ssq_w;
	assign cm = csum_q[26] ? 27'(-csum_q) : 27'(csum_q);
	assign sm = ssum_q[26] ? 27'(-ssum_q) : 27'(ssum_q);
	assign csq_w = cm * cm;
	assign ssq_w = sm * sm;
	assign sq_w = 56'(csq_w) + 56'(ssq_w);

	// Restoring square root, one result bit per cycle.
	logic [55:0] val_q;
	logic [29:0] trial;
	logic [29:0] rem_sh;
	assign rem_sh = {rem_q, val_q[55:54]};
	assign trial = {root_q, 2'b01};
	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			val_q <= sq_w; rem_q <= '0; root_q <= '0;
		end else if (cmd.sqrt_step) begin
			val_q <= val_q << 2;
			if (rem_sh >= trial) begin
				rem_q <= 28'(rem_sh - trial);
				root_q <= {root_q[26:0], 1'b1};
			end else begin
				rem_q <= 28'(rem_sh);
				root_q <= {root_q[26:0], 1'b0};
			end
		end
	end

	// Rounded division by the count, restoring, one bit per cycle.
	logic [CntW-1:0] nq;
	assign nq = cnt_q;
	logic [29:0] dtry;
	assign dtry = {drem_q, dnum_q[27]};
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dnum_q <= root_q + 28'(nq >> 1);
			drem_q <= '0; quo_q <= '0;
		end else if (cmd.div_step) begin
			dnum_q <= dnum_q << 1;
			if (dtry >= 30'(nq)) begin
				drem_q <= 29'(dtry - 30'(nq));
				quo_q <= {quo_q[14:0], 1'b1};
				if (dtry - 30'(nq) > 0 && quo_q[15]) quo_q <= 16'hFFFF;
			end else begin
				drem_q <= 29'(dtry);
				quo_q <= {quo_q[14:0], 1'b0};
			end
			if (quo_q[15]) begin
				quo_q <= 16'hFFFF;
			end
		end
	end

	// Result with the 1.0 cap.
	always_comb begin
		result.coherence = (quo_q > 16'd32768) ? 16'd32768 : quo_q;
		result.phase_count = 11'(cnt_q);
		result.too_many = ovf_q;
	end
	assign done = cmd.emit & (nq != '0);
endmodule
`default_nettype wire

[rtl/phase_coherence_order_parameter.sv]
// Top level of the phase coherence (Kuramoto order parameter) block.
// Depends on pcop_pkg, pcop_ctrl and pcop_datapath.
//
// Each phase transfer runs load, 16 CORDIC iterations and one accumulate,
// using the single shared CORDIC rotator. A phase marked last keeps busy high
// through the squared magnitude, the square root, the rounded division by the
// count with its set-up step and the emit; the result then shows on result
// with result_valid high for one cycle, rising as busy falls. The receiver
// cannot stall it.
`default_nettype none
module phase_coherence_order_parameter #(
	parameter int unsigned MAX_PHASES = 1024,
	parameter int unsigned ANGLE_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  pcop_pkg::in_item_t  item,
	output logic                result_valid,
	output pcop_pkg::out_item_t result
);
	pcop_pkg::cmd_t  cmd;
	pcop_pkg::stat_t stat;
	pcop_pkg::out_item_t res_w;
	logic done_w;

	pcop_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.stat(stat), .cmd(cmd)
	);

	pcop_datapath #(.MAX_PHASES(MAX_PHASES), .ANGLE_BITS(ANGLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .cmd(cmd), .stat(stat),
		.done(done_w), .result(res_w)
	);

	// Output register: one-cycle strobe with its payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= done_w;
	end
	always_ff @(posedge clk) begin
		if (done_w) result <= res_w;
	end
endmodule
`default_nettype wire
